// File: src/ltc_pkg.sv
// Shared types, constants and breakpoint tables for the e-paper waveform
// temperature compensator.
// No dependencies; imported by every module of the block.
package ltc_pkg;

	// Register and field widths
	localparam int TEMP_W      = 12;
	localparam int BYTE_W      = 8;
	localparam int FRAC_BITS   = 4;
	localparam logic signed [TEMP_W-1:0] TEMP_RESET = 12'sd400;

	// Table layout
	localparam int GROUP_BYTES = 153;
	localparam int GROUP_LEN   = 7;
	localparam int LAST_GATE   = 157;
	localparam int LAST_VCOM   = 158;
	localparam int BYTE_MAX    = 255;

	// Extra refresh window in whole degrees
	localparam int EXTRA_LO_DEG = 15;
	localparam int EXTRA_HI_DEG = 35;

	// Interpolation breakpoints: degrees, VCOM offset, gate offset, phase percent
	localparam int PT_COUNT = 8;
	localparam int PT_DEG   [PT_COUNT] = '{-10, 0, 10, 20, 25, 30, 40, 50};
	localparam int PT_VCOM  [PT_COUNT] = '{12, 8, 4, 2, 0, -2, -4, -8};
	localparam int PT_GATE  [PT_COUNT] = '{8, 6, 3, 1, 0, -1, -3, -6};
	localparam int PT_PHASE [PT_COUNT] = '{120, 110, 105, 102, 100, 98, 95, 90};
	localparam int SEG_W    = $clog2(PT_COUNT);

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// Byte handling class, decided at the front
	typedef enum logic [1:0] {
		CLS_PASS,
		CLS_VCOM,
		CLS_GATE,
		CLS_GATE_PHASE
	} cls_t;

	typedef struct packed {
		logic [BYTE_W-1:0] base_byte;
		cls_t              cls;
	} item_t;

	// Interpolated compensation values for the current temperature
	typedef struct packed {
		logic signed [8:0] vcom;
		logic signed [8:0] gate;
		logic [7:0]        phase;
		logic              extra;
	} coef_t;

endpackage

// File: src/ltc_coef.sv
// Temperature register and two-stage interpolation of VCOM offset, gate
// offset and phase multiplier from the breakpoint tables.
// Depends on ltc_pkg.
module ltc_coef import ltc_pkg::*; #(
	parameter int TEMP_FRAC_BITS = FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [TEMP_W-1:0]        wr_data,
	output coef_t                    coef
);

	localparam int SCALE  = 1 << TEMP_FRAC_BITS;
	localparam int CW     = ((TEMP_W > TEMP_FRAC_BITS + 7) ? TEMP_W : TEMP_FRAC_BITS + 7) + 1;
	localparam int NUMW   = TEMP_FRAC_BITS + 4;
	localparam int NW     = TEMP_FRAC_BITS + 10;
	localparam int XW     = NW - TEMP_FRAC_BITS;
	localparam int DEN_LONG  = 10 << TEMP_FRAC_BITS;
	localparam int DEN_SHORT = 5 << TEMP_FRAC_BITS;

	logic signed [TEMP_W-1:0] temp_q;

	logic signed [CW-1:0] tx;
	logic [SEG_W-1:0]     seg_cnt;
	logic [SEG_W-1:0]     seg_nx;
	logic signed [CW-1:0] num_full;

	logic [SEG_W-1:0] seg_s1;
	logic [NUMW-1:0]  num_s1;
	logic             short_s1;
	logic             clamp_lo_s1;
	logic             clamp_hi_s1;
	logic             extra_s1;

	logic [SEG_W-1:0] seg_hi_s1;
	coef_t            coef_d;
	coef_t            coef_s2;

	// Interpolate one value; trunc toward zero of (2*d*num + den) / (2*den)
	function automatic logic signed [8:0] lerp_val(
		input logic signed [8:0] a,
		input logic signed [8:0] b,
		input logic [NUMW-1:0]   num,
		input logic              short_seg
	);
		logic signed [8:0]    d;
		logic signed [NW-1:0] prod;
		logic signed [NW-1:0] n;
		logic [NW-1:0]        mag;
		logic [XW-1:0]        x;
		logic [XW+7:0]        qp;
		logic signed [8:0]    q;
		d    = b - a;
		prod = NW'(d) * NW'($signed({1'b0, num}));
		n    = (prod <<< 1) + (short_seg ? NW'(DEN_SHORT) : NW'(DEN_LONG));
		mag  = n[NW-1] ? NW'(-n) : NW'(n);
		x    = mag[NW-1:TEMP_FRAC_BITS];
		// long segments divide by twenty, short ones by ten
		if (!short_seg) begin
			x = x >> 1;
		end
		qp = (XW+8)'(x) * (XW+8)'(205);
		q  = $signed({2'b00, qp[XW+7:XW+1]});
		return n[NW-1] ? (a - q) : (a + q);
	endfunction

	// Hold the temperature register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= TEMP_RESET;
		end else if (wr_en) begin
			temp_q <= $signed(wr_data);
		end
	end

	// Pick the segment and the offset into it
	always_comb begin
		tx      = CW'(temp_q);
		seg_cnt = '0;
		for (int j = 1; j < PT_COUNT - 1; j++) begin
			if (tx > CW'(PT_DEG[j] * SCALE)) begin
				seg_cnt = seg_cnt + SEG_W'(1);
			end
		end
		seg_nx   = seg_cnt + SEG_W'(1);
		num_full = tx - CW'(PT_DEG[seg_cnt] * SCALE);
	end

	always_ff @(posedge clk) begin
		seg_s1      <= seg_cnt;
		num_s1      <= num_full[NUMW-1:0];
		short_s1    <= ((PT_DEG[seg_nx] - PT_DEG[seg_cnt]) == 5);
		clamp_lo_s1 <= (tx <= CW'(PT_DEG[0] * SCALE));
		clamp_hi_s1 <= (tx >= CW'(PT_DEG[PT_COUNT-1] * SCALE));
		extra_s1    <= (tx < CW'(EXTRA_LO_DEG * SCALE)) || (tx > CW'(EXTRA_HI_DEG * SCALE));
	end

	// Evaluate the three values, or take an end entry when clamped
	always_comb begin
		seg_hi_s1 = seg_s1 + SEG_W'(1);
		if (clamp_lo_s1) begin
			coef_d.vcom  = 9'(PT_VCOM[0]);
			coef_d.gate  = 9'(PT_GATE[0]);
			coef_d.phase = 8'(PT_PHASE[0]);
		end else if (clamp_hi_s1) begin
			coef_d.vcom  = 9'(PT_VCOM[PT_COUNT-1]);
			coef_d.gate  = 9'(PT_GATE[PT_COUNT-1]);
			coef_d.phase = 8'(PT_PHASE[PT_COUNT-1]);
		end else begin
			coef_d.vcom  = lerp_val(9'(PT_VCOM[seg_s1]), 9'(PT_VCOM[seg_hi_s1]),
				num_s1, short_s1);
			coef_d.gate  = lerp_val(9'(PT_GATE[seg_s1]), 9'(PT_GATE[seg_hi_s1]),
				num_s1, short_s1);
			coef_d.phase = 8'(lerp_val(9'(PT_PHASE[seg_s1]), 9'(PT_PHASE[seg_hi_s1]),
				num_s1, short_s1));
		end
		coef_d.extra = extra_s1;
	end

	always_ff @(posedge clk) begin
		coef_s2 <= coef_d;
	end

	assign coef = coef_s2;

endmodule

// File: src/ltc_front.sv
// Front stage: takes input requests and classifies each byte by its index.
// Depends on ltc_pkg.
module ltc_front import ltc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] base_byte,
	input  logic [BYTE_W-1:0] byte_index,
	input  logic              q_full,
	output logic              push,
	output item_t             push_item
);

	logic              valid_s1;
	item_t             item_s1;
	item_t             item_d;
	logic              accept;
	logic [BYTE_W-1:0] grp;
	logic [17:0]       grp_prod;
	logic [BYTE_W-1:0] pos;

	// Hold off new requests only while the stage register cannot drain
	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	// Position within a 7-byte group, divide by reciprocal
	always_comb begin
		grp_prod = 18'(byte_index) * 18'd147;
		grp      = grp_prod[17:10];
		pos      = byte_index - BYTE_W'(grp * BYTE_W'(GROUP_LEN));

		item_d.base_byte = base_byte;
		if (byte_index < BYTE_W'(GROUP_BYTES)) begin
			case (pos)
				8'd0:       item_d.cls = CLS_VCOM;
				8'd1, 8'd2: item_d.cls = CLS_GATE_PHASE;
				default:    item_d.cls = CLS_PASS;
			endcase
		end else if (byte_index <= BYTE_W'(LAST_GATE)) begin
			item_d.cls = CLS_GATE;
		end else if (byte_index == BYTE_W'(LAST_VCOM)) begin
			item_d.cls = CLS_VCOM;
		end else begin
			item_d.cls = CLS_PASS;
		end
	end

	// Load on accept, drop once handed to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: src/ltc_queue.sv
// Short queue of classified requests between front and back.
// Depends on ltc_pkg.
module ltc_queue import ltc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  not_empty,
	output logic  full
);

	item_t              fifo_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign head      = fifo_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (Q_PTR_W+1)'(Q_DEPTH));

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (Q_PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (Q_PTR_W+1)'(1);
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: src/ltc_back.sv
// Back end: applies offsets and phase scaling, then divides and saturates
// into the output register.
// Depends on ltc_pkg.
module ltc_back import ltc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             head,
	input  logic              not_empty,
	output logic              pop,
	input  coef_t             coef,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] compensated_byte,
	output logic              extra_refresh
);

	logic              valid_s2;
	logic [14:0]       res_s2;
	logic              scale_s2;
	logic              extra_s2;
	logic              valid_s3;
	logic [BYTE_W-1:0] byte_s3;
	logic              extra_s3;

	logic              adv3;
	logic              load2;
	logic [BYTE_W-1:0] sum_v;
	logic [BYTE_W-1:0] sum_g;
	logic [14:0]       res_d;
	logic              scale_d;
	logic [27:0]       div_prod;
	logic [8:0]        quot;
	logic [BYTE_W-1:0] byte_d;

	// Add a signed offset and saturate to a byte
	function automatic logic [BYTE_W-1:0] add_sat(
		input logic [BYTE_W-1:0] b,
		input logic signed [8:0] off
	);
		logic signed [9:0] r;
		r = $signed({2'b00, b}) + 10'(off);
		if (r < 0) begin
			return '0;
		end else if (r > 10'sd255) begin
			return BYTE_W'(BYTE_MAX);
		end
		return r[BYTE_W-1:0];
	endfunction

	assign adv3  = !valid_s3 || !out_stall;
	assign load2 = !valid_s2 || adv3;
	assign pop   = not_empty && load2;

	// Offset and phase product
	always_comb begin
		sum_v   = add_sat(head.base_byte, coef.vcom);
		sum_g   = add_sat(head.base_byte, coef.gate);
		scale_d = 1'b0;
		case (head.cls)
			CLS_VCOM: res_d = 15'(sum_v);
			CLS_GATE: res_d = 15'(sum_g);
			CLS_GATE_PHASE: begin
				res_d   = 15'(sum_g) * 15'(coef.phase);
				scale_d = 1'b1;
			end
			default:  res_d = 15'(head.base_byte);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load2) begin
			valid_s2 <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s2   <= res_d;
			scale_s2 <= scale_d;
			extra_s2 <= coef.extra;
		end
	end

	// Divide by one hundred via reciprocal, saturate
	always_comb begin
		div_prod = 28'(res_s2) * 28'd5243;
		quot     = div_prod[27:19];
		if (scale_s2) begin
			byte_d = (quot > 9'(BYTE_MAX)) ? BYTE_W'(BYTE_MAX) : quot[BYTE_W-1:0];
		end else begin
			byte_d = res_s2[BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			byte_s3  <= byte_d;
			extra_s3 <= extra_s2;
		end
	end

	assign out_valid        = valid_s3;
	assign compensated_byte = byte_s3;
	assign extra_refresh    = extra_s3;

endmodule

// File: src/epd_lut_temp_compensator.sv
// Path: classifying front register, queue, then the offset/multiply stage and
// the reciprocal-divide output register. Throughput: one byte per cycle while
// out_stall is low; a four-entry queue decouples the front from the back end.
// Reset: queue, stage valids empty; temperature register returns to 25 degC.
// Interpolated values follow a write via the temperature and stage registers.
// Depends on ltc_pkg, ltc_coef, ltc_front, ltc_queue, ltc_back.
module epd_lut_temp_compensator import ltc_pkg::*; #(
	parameter int TEMP_FRAC_BITS = FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [TEMP_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] base_byte,
	input  logic [BYTE_W-1:0] byte_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] compensated_byte,
	output logic              extra_refresh
);

	coef_t coef;
	logic  q_full;
	logic  q_not_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t head;

	ltc_coef #(
		.TEMP_FRAC_BITS(TEMP_FRAC_BITS)
	) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_wr_en),
		.wr_data (cfg_wr_data),
		.coef    (coef)
	);

	ltc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.base_byte  (base_byte),
		.byte_index (byte_index),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	ltc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	ltc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.not_empty        (q_not_empty),
		.pop              (pop),
		.coef             (coef),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.compensated_byte (compensated_byte),
		.extra_refresh    (extra_refresh)
	);

endmodule

// File: verif/epd_lut_temp_compensator_test.sv
// Self-checking testbench for epd_lut_temp_compensator: predicts every compensated
// byte and refresh flag per temperature setting, checks results in order under flow control.
// Depends on ltc_pkg and the epd_lut_temp_compensator RTL.
module epd_lut_temp_compensator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ltc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PIPE_SETTLE = 8;
	localparam int PHASES      = 24;
	localparam int PHASE_ITEMS = 36;
	localparam int HOLD_PHASE  = 5;
	localparam int HOLD_CYCLES = 200;
	localparam int TEMP_MIN    = -880;
	localparam int TEMP_MAX    = 2000;

	// Directed temperatures: range ends, table ends, breakpoints, refresh window edges and their neighbours
	localparam int TEMP_POINTS [19] = '{
		-880, 2000, -160, -161, -159, 0, 8, 160, 240, 239,
		241, 320, 400, 480, 560, 561, 799, 800, -1
	};

	// Directed requests as {base byte, index}
	localparam logic [15:0] DIRECTED [24] = '{
		{8'd0, 8'd0}, {8'd255, 8'd0}, {8'd0, 8'd1}, {8'd255, 8'd1},
		{8'd200, 8'd2}, {8'd255, 8'd2}, {8'd0, 8'd3}, {8'd255, 8'd6},
		{8'd128, 8'd7}, {8'd250, 8'd14}, {8'd5, 8'd145}, {8'd255, 8'd152},
		{8'd0, 8'd152}, {8'd255, 8'd153}, {8'd250, 8'd157}, {8'd0, 8'd157},
		{8'd255, 8'd158}, {8'd0, 8'd158}, {8'd77, 8'd159}, {8'd200, 8'd255},
		{8'd0, 8'd255}, {8'd255, 8'd8}, {8'd1, 8'd9}, {8'd100, 8'd4}
	};

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              extra;
	} comp_result_t;

	// Predict compensated bytes and hold them until the block returns them
	class comp_scoreboard;
		int           panel_temp = TEMP_RESET;
		comp_result_t compensated_due [$];
		int           mismatches = 0;

		function void set_temperature(logic signed [TEMP_W-1:0] t);
			panel_temp = t;
		endfunction

		function int pending();
			return compensated_due.size();
		endfunction

		// Round half up, then truncate toward zero
		function int ramp(int a, int b, int num, int den);
			return a + (2 * (b - a) * num + den) / (2 * den);
		endfunction

		function int add_offset(int v, int off);
			int r;
			r = v + off;
			if (r < 0)
				return 0;
			if (r > BYTE_MAX)
				return BYTE_MAX;
			return r;
		endfunction

		function comp_result_t compensate(logic [BYTE_W-1:0] base, logic [BYTE_W-1:0] idx);
			int           scale;
			int           vcom;
			int           gate;
			int           phase;
			int           seg;
			int           num;
			int           den;
			int           r;
			int           pos;
			comp_result_t res;
			scale = 1 << FRAC_BITS;
			// Clamp to the table ends, else interpolate within the lower segment
			if (panel_temp <= PT_DEG[0] * scale) begin
				vcom  = PT_VCOM[0];
				gate  = PT_GATE[0];
				phase = PT_PHASE[0];
			end else if (panel_temp >= PT_DEG[PT_COUNT-1] * scale) begin
				vcom  = PT_VCOM[PT_COUNT-1];
				gate  = PT_GATE[PT_COUNT-1];
				phase = PT_PHASE[PT_COUNT-1];
			end else begin
				seg = 0;
				while (seg < PT_COUNT - 2 && panel_temp > PT_DEG[seg+1] * scale)
					seg++;
				num   = panel_temp - PT_DEG[seg] * scale;
				den   = (PT_DEG[seg+1] - PT_DEG[seg]) * scale;
				vcom  = ramp(PT_VCOM[seg], PT_VCOM[seg+1], num, den);
				gate  = ramp(PT_GATE[seg], PT_GATE[seg+1], num, den);
				phase = ramp(PT_PHASE[seg], PT_PHASE[seg+1], num, den);
			end
			// Apply offsets by table position
			r = base;
			if (idx < GROUP_BYTES) begin
				pos = idx % GROUP_LEN;
				if (pos == 0) begin
					r = add_offset(base, vcom);
				end else if (pos <= 2) begin
					r = add_offset(base, gate) * phase / 100;
					if (r > BYTE_MAX)
						r = BYTE_MAX;
				end
			end else if (idx <= LAST_GATE) begin
				r = add_offset(base, gate);
			end else if (idx == LAST_VCOM) begin
				r = add_offset(base, vcom);
			end
			res.value = r[BYTE_W-1:0];
			res.extra = (panel_temp < EXTRA_LO_DEG * scale) ||
			            (panel_temp > EXTRA_HI_DEG * scale);
			return res;
		endfunction

		function void note_request(logic [BYTE_W-1:0] base, logic [BYTE_W-1:0] idx);
			compensated_due.push_back(compensate(base, idx));
		endfunction

		function void check_result(logic [BYTE_W-1:0] value, logic extra);
			comp_result_t want;
			if (compensated_due.size() == 0) begin
				$display("%0t: result with no request outstanding, actual byte %0d extra %0b",
				         $time, value, extra);
				mismatches++;
				return;
			end
			want = compensated_due.pop_front();
			if (value !== want.value) begin
				$display("%0t: compensated_byte mismatch, expected %0d, actual %0d",
				         $time, want.value, value);
				mismatches++;
			end
			if (extra !== want.extra) begin
				$display("%0t: extra_refresh mismatch, expected %0b, actual %0b",
				         $time, want.extra, extra);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [TEMP_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BYTE_W-1:0] base_byte = '0;
	logic [BYTE_W-1:0] byte_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BYTE_W-1:0] compensated_byte;
	logic              extra_refresh;

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_pending = 1'b0;

	comp_scoreboard sb = new();

	epd_lut_temp_compensator u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.base_byte        (base_byte),
		.byte_index       (byte_index),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.compensated_byte (compensated_byte),
		.extra_refresh    (extra_refresh)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Note accepted requests and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(base_byte, byte_index);
			if (out_valid && !out_stall)
				sb.check_result(compensated_byte, extra_refresh);
		end
	end

	// Stall the output at random, or hold off for a long stretch on demand
	initial begin : receiver
		int hold_count;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				hold_count = 0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Abort a run that hangs
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[epd_lut_temp_compensator] ERROR");
		$finish;
	end

	// Offer one request after a random gap and hold it until accepted
	task automatic send_request(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		base_byte  <= b;
		byte_index <= idx;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Bias bytes toward the saturation ends, indices mostly inside the table
	task automatic send_random_request();
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] idx;
		case ($urandom_range(7))
			0: b = BYTE_W'($urandom_range(8));
			1: b = BYTE_W'($urandom_range(255, 247));
			default: b = BYTE_W'($urandom_range(255));
		endcase
		if ($urandom_range(7) == 0)
			idx = BYTE_W'($urandom_range(255, LAST_VCOM + 1));
		else
			idx = BYTE_W'($urandom_range(LAST_VCOM));
		send_request(b, idx);
	endtask

	// Wait for every outstanding result, then let the pipeline empty
	task automatic wait_drained();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// Write the temperature register while idle, then let the coefficients settle
	task automatic write_temperature(input logic signed [TEMP_W-1:0] t);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= t;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_temperature(t);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int t;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the cold end: every position class and saturation
		write_temperature(TEMP_W'(TEMP_MIN));
		foreach (DIRECTED[k])
			send_request(DIRECTED[k][15:8], DIRECTED[k][7:0]);
		in_valid <= 1'b0;

		// Random phases, one temperature setting and one idling mode each
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < $size(TEMP_POINTS))
				t = TEMP_POINTS[ph];
			else
				t = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
			write_temperature(TEMP_W'(t));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			// Fill the block against a long output hold-off
			if (ph == HOLD_PHASE) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				hold_pending   = 1'b1;
			end
			repeat (PHASE_ITEMS) send_random_request();
			in_valid <= 1'b0;
		end

		wait_drained();
		if (sb.mismatches == 0)
			$display("[epd_lut_temp_compensator] OK");
		else
			$display("[epd_lut_temp_compensator] ERROR");
		$finish;
	end

endmodule

// File: epd_lut_temp_compensator.f
src/ltc_pkg.sv
src/ltc_coef.sv
src/ltc_front.sv
src/ltc_queue.sv
src/ltc_back.sv
src/epd_lut_temp_compensator.sv
verif/epd_lut_temp_compensator_test.sv
